// ----- rtl/vgr_pkg.sv -----
// ----------------------------------------------------------------------------
// vgr_pkg: shared definitions for the volume gain ramp block
// Field widths, fixed-point formats, command codes, the unit request types
// and the table of fractional powers of two used by the gain conversion.
// ----------------------------------------------------------------------------
package vgr_pkg;

  // Field and state widths.
  localparam int SAMPLE_W  = 24;              // audio sample
  localparam int GAIN_FRAC = 24;              // fraction bits of a Q4 gain
  localparam int GAIN_W    = GAIN_FRAC + 4;   // reported gain, Q4.24
  localparam int RAMP_W    = 12;              // ramp length register
  localparam int EXTRA_W   = 12;              // extra fraction bits of the running gain
  localparam int TGT_W     = GAIN_W + 2;      // target gain, room for unsaturated levels
  localparam int CUR_W     = TGT_W + EXTRA_W; // running gain
  localparam int STEP_W    = CUR_W + 1;       // signed ramp step
  localparam int DIV_W     = CUR_W;           // magnitude of the ramp difference
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CDB_W     = 15;              // level in hundredths of a dB

  // Gain conversion.
  localparam int Q30        = 30;
  localparam int ROOT_W     = Q30 + 1;
  localparam int ROOT_COUNT = 10;
  localparam int K_W        = $clog2(ROOT_COUNT + 1);
  localparam int DB_SHIFT   = 16;             // the dB constant is Q16
  localparam int SHIFT_BIAS = Q30 - GAIN_FRAC;

  // Shared serial multiplier: signed multiplicand, unsigned multiplier.
  localparam int MC_W   = 32;
  localparam int MP_W   = ROOT_W;
  localparam int MCNT_W = $clog2(MP_W + 1);

  localparam logic [MP_W-1:0]   DB_TO_EXP_Q16  = MP_W'(111465);
  localparam logic [MCNT_W-1:0] MUL_STEPS_SMP  = MCNT_W'(TGT_W);
  localparam logic [MCNT_W-1:0] MUL_STEPS_DB   = MCNT_W'(17);
  localparam logic [MCNT_W-1:0] MUL_STEPS_ROOT = MCNT_W'(ROOT_W);

  localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(240);

  // Item commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_VOLUME = 1'b1;

  // Request to the serial multiplier.
  typedef struct packed {
    logic                     start;
    logic signed [MC_W-1:0]   mcand;
    logic        [MP_W-1:0]   mplier;
    logic        [MCNT_W-1:0] steps;
  } vgr_mul_req_t;

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [RAMP_W-1:0] divisor;
  } vgr_div_req_t;

  typedef logic [ROOT_W-1:0] vgr_root_tab_t [ROOT_COUNT];

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] vgr_isqrt(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Factors 2^(2^-k) in Q30 for k = 1..10, by repeated square roots of 2.0.
  function automatic vgr_root_tab_t vgr_gen_roots();
    logic [63:0]   r;
    vgr_root_tab_t tab;
    r = 64'd1 << 31;
    for (int k = 0; k < ROOT_COUNT; k++) begin
      r      = vgr_isqrt(r << Q30);
      tab[k] = r[ROOT_W-1:0];
    end
    return tab;
  endfunction

  localparam vgr_root_tab_t ROOT_TAB = vgr_gen_roots();

endpackage

// ----- rtl/vgr_if.sv -----
// ----------------------------------------------------------------------------
// vgr_if: valid/ready channels of the volume gain ramp block
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------
interface vgr_in_if import vgr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       frame_start;
  logic signed [CDB_W-1:0]    volume_centi_db;

  modport source (output valid, command, sample_in, frame_start, volume_centi_db,
                  input ready);
  modport sink (input valid, command, sample_in, frame_start, volume_centi_db,
                output ready);
endinterface

interface vgr_out_if import vgr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic        [GAIN_W-1:0]   gain_used;

  modport source (output valid, sample_out, gain_used, input ready);
  modport sink (input valid, sample_out, gain_used, output ready);
endinterface

// ----- rtl/vgr_smul.sv -----
// ----------------------------------------------------------------------------
// vgr_smul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// After N steps the low N product bits sit at the top of prod_lo and the
// upper product bits in prod_hi.
// ----------------------------------------------------------------------------
module vgr_smul import vgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vgr_mul_req_t           req,
  output logic                   busy,
  output logic signed [MC_W-1:0] prod_hi,
  output logic        [MP_W-1:0] prod_lo
);

  logic                   busy_r;
  logic [MCNT_W-1:0]      cnt_r;
  logic signed [MC_W-1:0] m_r;
  logic signed [MC_W-1:0] hi_r;
  logic [MP_W-1:0]        lo_r;
  logic [MC_W-1:0]        addend;
  logic [MC_W:0]          sum;

  // Add the multiplicand when the current multiplier bit is set.
  always_comb begin
    addend = lo_r[0] ? m_r : '0;
    sum    = {hi_r[MC_W-1], hi_r} + {addend[MC_W-1], addend};
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - MCNT_W'(1);
      if (cnt_r == MCNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Partial product shifts right; product bits move into the multiplier word.
  always_ff @(posedge clk) begin
    if (req.start) begin
      m_r  <= req.mcand;
      hi_r <= '0;
      lo_r <= req.mplier;
    end else if (busy_r) begin
      hi_r <= sum[MC_W:1];
      lo_r <= {sum[0], lo_r[MP_W-1:1]};
    end
  end

  assign busy    = busy_r;
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

// ----- rtl/vgr_sdiv.sv -----
// ----------------------------------------------------------------------------
// vgr_sdiv: bit-serial restoring divider
// Unsigned dividend by the ramp length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgr_sdiv import vgr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  vgr_div_req_t     req,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [RAMP_W-1:0]    rem_r;
  logic [RAMP_W-1:0]    d_r;
  logic [RAMP_W:0]      trial;
  logic [RAMP_W:0]      diff;
  logic                 fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, d_r};
    fits  = trial >= {1'b0, d_r};
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Dividend bits shift out the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/volume_gain_with_linear_ramp.sv -----
// Sample transaction: the result is registered after a 30-step serial multiply once the
//   output register is free; the next item is accepted after the result is registered.
// Volume transaction: 17-step dB multiply, up to ten 31-step root multiplies, up to
//   34 one-bit shift steps and, after the first level, a 42-step divide; no result.
// Reset (synchronous, active low): unity gain, no ramp, ramp_frames 240, no clearing pass.
// ----------------------------------------------------------------------------
// volume_gain_with_linear_ramp: volume control with a linear gain ramp
// Converts levels in hundredths of a dB to a linear gain, ramps the gain over
// a number of frames and multiplies each sample by it with rounding and
// saturation.
// ----------------------------------------------------------------------------
module volume_gain_with_linear_ramp import vgr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vgr_in_if.sink            in_ch,
  vgr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [RAMP_W-1:0] cfg_wdata
);

  localparam int RSH_W  = 6;
  localparam int FRAC_W = ROOT_COUNT;
  localparam int E_W    = 17;
  localparam int IP_W   = E_W - FRAC_W;
  localparam int SMP_LO = MP_W - TGT_W;
  localparam int DB_LO  = MP_W - 17;
  localparam int EXT_W  = MC_W + TGT_W - GAIN_FRAC;

  localparam logic [ROOT_W-1:0] ONE_Q30   = ROOT_W'(1) << Q30;
  localparam logic [TGT_W-1:0]  GAIN_MAXT = TGT_W'({GAIN_W{1'b1}});
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV, ST_MUL_SMP, ST_MUL_DB, ST_ROOT, ST_ROOT_MUL,
    ST_SHIFT, ST_APPLY, ST_DIV_GO, ST_DIV
  } state_t;

  state_t state_r, state_nxt;

  logic [RAMP_W-1:0]          ramp_frames_r;
  logic [CUR_W-1:0]           cur_r, cur_nxt;
  logic [TGT_W-1:0]           tgt_r, tgt_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [RAMP_W-1:0]          left_r, left_nxt;
  logic                       set_r, set_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic [GAIN_W-1:0]          out_gain_r, out_gain_nxt;

  logic signed [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic                       fs_r, fs_nxt;
  logic [ROOT_W-1:0]          p_r, p_nxt;
  logic [K_W-1:0]             k_r, k_nxt;
  logic [FRAC_W-1:0]          frac_r, frac_nxt;
  logic                       gsat_r, gsat_nxt;
  logic [RSH_W-1:0]           rsh_r, rsh_nxt;
  logic [STEP_W-1:0]          diff_r, diff_nxt;

  vgr_mul_req_t           mul_req;
  vgr_div_req_t           div_req;
  logic                   mul_busy;
  logic signed [MC_W-1:0] mul_hi;
  logic [MP_W-1:0]        mul_lo;
  logic                   div_busy;
  logic [DIV_W-1:0]       div_quo;

  logic                   acc_in;
  logic                   out_free;
  logic [RAMP_W-1:0]      frames;
  logic [CUR_W-1:0]       snap;
  logic                   adv;
  logic [CUR_W-1:0]       cur_adv;
  logic [MC_W-1:0]        smp_ext;
  logic [MC_W-1:0]        cdb_ext;
  logic [EXT_W-1:0]       y_ext;
  logic [EXT_W-1:0]       y_sum;
  logic [SAMPLE_W-1:0]    y_sat;
  logic [E_W-1:0]         e10;
  logic [IP_W-1:0]        ipart;
  logic [IP_W-1:0]        rsh_full;
  logic [ROOT_W-1:0]      root_prod;
  logic [STEP_W-1:0]      mag;

  // Serial arithmetic units.
  vgr_smul u_smul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .busy    (mul_busy),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo)
  );

  vgr_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Handshakes and shared views of the state.
  always_comb begin
    acc_in   = in_ch.valid && (state_r == ST_IDLE);
    out_free = !out_valid_r || out_ch.ready;
    frames   = (ramp_frames_r == '0) ? RAMP_W'(1) : ramp_frames_r;
    snap     = {tgt_r, {EXTRA_W{1'b0}}};
    smp_ext  = {{(MC_W - SAMPLE_W){smp_r[SAMPLE_W-1]}}, smp_r};
    cdb_ext  = {{(MC_W - CDB_W){in_ch.volume_centi_db[CDB_W-1]}}, in_ch.volume_centi_db};
    mag      = diff_r[STEP_W-1] ? (-diff_r) : diff_r;
  end

  // Gain advance on a frame start while a ramp runs; it lands on the target.
  always_comb begin
    adv = fs_r && (left_r != '0);
    if (!adv) begin
      cur_adv = cur_r;
    end else if (left_r == RAMP_W'(1)) begin
      cur_adv = snap;
    end else begin
      cur_adv = cur_r + step_r[CUR_W-1:0];
    end
  end

  // Sample result: round half up at bit 23 of the product, then saturate.
  always_comb begin
    y_ext = {mul_hi, mul_lo[MP_W-1:SMP_LO+GAIN_FRAC]};
    y_sum = y_ext + EXT_W'(mul_lo[SMP_LO+GAIN_FRAC-1]);
    if ($signed(y_sum) > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_W-1:0];
    end else if ($signed(y_sum) < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      y_sat = y_sum[SAMPLE_W-1:0];
    end
  end

  // Exponent in Q10 from the dB product, and the root-factor product in Q30.
  always_comb begin
    e10 = {mul_hi[E_W-2:0], mul_lo[MP_W-1:DB_LO+DB_SHIFT]}
          + E_W'(mul_lo[DB_LO+DB_SHIFT-1]);
    ipart     = e10[E_W-1:FRAC_W];
    rsh_full  = IP_W'(SHIFT_BIAS) - ipart;
    root_prod = {mul_hi[ROOT_W-2:0], mul_lo[MP_W-1]};
  end

  // Sequencer next state and unit requests.
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    tgt_nxt        = tgt_r;
    step_nxt       = step_r;
    left_nxt       = left_r;
    set_nxt        = set_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_gain_nxt   = out_gain_r;
    smp_nxt        = smp_r;
    fs_nxt         = fs_r;
    p_nxt          = p_r;
    k_nxt          = k_r;
    frac_nxt       = frac_r;
    gsat_nxt       = gsat_r;
    rsh_nxt        = rsh_r;
    diff_nxt       = diff_r;

    mul_req.start  = 1'b0;
    mul_req.mcand  = smp_ext;
    mul_req.mplier = {1'b0, cur_adv[CUR_W-1:EXTRA_W]};
    mul_req.steps  = MUL_STEPS_SMP;

    div_req.start    = 1'b0;
    div_req.dividend = mag[DIV_W-1:0];
    div_req.divisor  = frames;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          smp_nxt = in_ch.sample_in;
          fs_nxt  = in_ch.frame_start;
          if (in_ch.command == CMD_VOLUME) begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = cdb_ext;
            mul_req.mplier = DB_TO_EXP_Q16;
            mul_req.steps  = MUL_STEPS_DB;
            state_nxt      = ST_MUL_DB;
          end else begin
            state_nxt = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        mul_req.start = 1'b1;
        cur_nxt       = cur_adv;
        if (adv) begin
          left_nxt = left_r - RAMP_W'(1);
        end
        state_nxt = ST_MUL_SMP;
      end
      ST_MUL_SMP: begin
        if (!mul_busy && out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_sat;
          out_gain_nxt   = cur_r[GAIN_W+EXTRA_W-1:EXTRA_W];
          state_nxt      = ST_IDLE;
        end
      end
      ST_MUL_DB: begin
        if (!mul_busy) begin
          frac_nxt  = e10[FRAC_W-1:0];
          gsat_nxt  = $signed(ipart) >= $signed(IP_W'(SHIFT_BIAS));
          rsh_nxt   = rsh_full[RSH_W-1:0];
          p_nxt     = ONE_Q30;
          k_nxt     = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (k_r == K_W'(ROOT_COUNT)) begin
          if (gsat_r) begin
            tgt_nxt   = GAIN_MAXT;
            state_nxt = ST_APPLY;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end else if (frac_r[FRAC_W-1]) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {1'b0, p_r};
          mul_req.mplier = ROOT_TAB[k_r];
          mul_req.steps  = MUL_STEPS_ROOT;
          state_nxt      = ST_ROOT_MUL;
        end else begin
          k_nxt    = k_r + K_W'(1);
          frac_nxt = frac_r << 1;
        end
      end
      ST_ROOT_MUL: begin
        if (!mul_busy) begin
          p_nxt     = root_prod;
          k_nxt     = k_r + K_W'(1);
          frac_nxt  = frac_r << 1;
          state_nxt = ST_ROOT;
        end
      end
      ST_SHIFT: begin
        // Truncating right shift into Q6.24, one bit per cycle.
        if (rsh_r == '0) begin
          tgt_nxt   = p_r[TGT_W-1:0];
          state_nxt = ST_APPLY;
        end else begin
          p_nxt   = p_r >> 1;
          rsh_nxt = rsh_r - RSH_W'(1);
        end
      end
      ST_APPLY: begin
        if (!set_r) begin
          cur_nxt   = snap;
          step_nxt  = '0;
          left_nxt  = '0;
          set_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          diff_nxt  = {1'b0, snap} - {1'b0, cur_r};
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        // Quotient truncates toward zero, so the sign is applied afterwards.
        if (!div_busy) begin
          step_nxt  = diff_r[STEP_W-1] ? (-{1'b0, div_quo}) : {1'b0, div_quo};
          left_nxt  = frames;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, gain state and registered outputs.
  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_gain_r   <= out_gain_nxt;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ramp_frames_r <= RAMP_RESET;
      cur_r         <= CUR_W'(1) << (GAIN_FRAC + EXTRA_W);
      tgt_r         <= TGT_W'(1) << GAIN_FRAC;
      step_r        <= '0;
      left_r        <= '0;
      set_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      step_r      <= step_nxt;
      left_r      <= left_nxt;
      set_r       <= set_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ramp_frames_r <= cfg_wdata;
      end
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    smp_r        <= smp_nxt;
    fs_r         <= fs_nxt;
    p_r          <= p_nxt;
    k_r          <= k_nxt;
    frac_r       <= frac_nxt;
    gsat_r       <= gsat_nxt;
    rsh_r        <= rsh_nxt;
    diff_r       <= diff_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.gain_used  = out_gain_r;

endmodule

// ----- rtl/vgr_checker.sv -----
// ----------------------------------------------------------------------------
// vgr_checker: port-level checks of the volume gain ramp block
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module vgr_checker import vgr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_command,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample,
  input logic [GAIN_W-1:0]   out_gain
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One transaction at a time: input closes after each acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // A volume transaction never produces a result.
  a_volume_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_VOLUME) && !out_valid |=> !out_valid)
    else $error("result after volume transaction");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_gain))
    else $error("stalled result changed");

endmodule

bind volume_gain_with_linear_ramp vgr_checker u_vgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_gain   (out_ch.gain_used)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for volume_gain_with_linear_ramp
// Drives samples and level changes through the valid/ready channels, predicts
// the gained sample and the gain in use for each sample transaction, and
// compares every result in order. A directed table is run first, then random
// framed traffic under several ramp lengths and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import vgr_pkg::*;

  localparam int          SETTLE_CYCLES = 500;       // margin for a level change to complete
  localparam int          CYCLE_LIMIT   = 3_000_000;
  localparam int          PHASE_ITEMS   = 216;
  localparam int          PHASES        = 6;
  localparam longint      DB_EXP_Q16    = 111465;    // 1024*log2(10)/2000 in Q16
  localparam logic [63:0] GAIN_TOP      = 64'h0FFF_FFFF;
  localparam logic [63:0] UNITY_RUN     = 64'd1 << (GAIN_FRAC + EXTRA_W);
  localparam logic [63:0] UNITY_GOAL    = 64'd1 << GAIN_FRAC;
  localparam longint      SMP_HI        = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint      SMP_LO        = -SMP_HI - 1;
  localparam logic [GAIN_W-1:0] UNITY_G = GAIN_W'(UNITY_GOAL);
  localparam logic [GAIN_W-1:0] MAX_G   = GAIN_W'(GAIN_TOP);

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       fs;
    logic signed [CDB_W-1:0]    cdb;
  } vol_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic        [GAIN_W-1:0]   gain;
  } gained_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    vol_item_t         it;
    logic [RAMP_W-1:0] cfg_val;
    logic              typed;
    gained_t           want;
  } dir_row_t;

  localparam int PLAN_LEN = 26;

  // Directed rows: reset gain, field extremes, snap, saturation, short and
  // long ramps, retarget mid-ramp and a ramp length change during a ramp.
  localparam dir_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh7FFFFF, 1'b1, 15'sh0000}, 12'd0, 1'b1,
      '{24'sh7FFFFF, UNITY_G}},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh800000, 1'b0, 15'sh7FFF}, 12'd0, 1'b1,
      '{24'sh800000, UNITY_G}},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh000000, 1'b1, 15'sh4000}, 12'd0, 1'b1,
      '{24'sh000000, UNITY_G}},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh7FFFFF, 1'b1, 15'sh4000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh7FFFFF, 1'b1, 15'sh0000}, 12'd0, 1'b1,
      '{24'sh000000, '0}},
    '{ROW_CFG,  '0, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh800000, 1'b0, 15'sh3FFF}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh123456, 1'b0, 15'sh1234}, 12'd0, 1'b1,
      '{24'sh000000, '0}},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh000001, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh7FFFFF, 1'b0, 15'sh0000}, 12'd0, 1'b1,
      '{24'sh7FFFFF, MAX_G}},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh800000, 1'b0, 15'sh0000}, 12'd0, 1'b1,
      '{24'sh800000, MAX_G}},
    '{ROW_CFG,  '0, 12'd1, 1'b0, '0},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh000000, 1'b0, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh000005, 1'b1, 15'sh0000}, 12'd0, 1'b1,
      '{24'sh000005, UNITY_G}},
    '{ROW_CFG,  '0, 12'hFFF, 1'b0, '0},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh000000, 1'b0, 15'sd2400}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh3A5C71, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'shC0FFEE, 1'b0, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh000000, 1'b0, -15'sd9600}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh400000, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_CFG,  '0, 12'd3, 1'b0, '0},
    '{ROW_ITEM, '{CMD_VOLUME, 24'sh000000, 1'b0, 15'sd2400}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh7FFFFF, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh800000, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh2AAAAA, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0},
    '{ROW_ITEM, '{CMD_SAMPLE, 24'sh555555, 1'b1, 15'sh0000}, 12'd0, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RAMP_W-1:0] cfg_wdata;

  vgr_in_if  in_if ();
  vgr_out_if out_if ();

  volume_gain_with_linear_ramp DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted gain state, Q4.36 running gain and Q4.24 goal.
  logic [63:0] pow_roots [ROOT_COUNT];
  logic [63:0] run_gain         = UNITY_RUN;
  logic [63:0] goal_gain        = UNITY_GOAL;
  longint      ramp_inc         = 0;
  longint      ramp_frames_left = 0;
  bit          level_applied    = 1'b0;
  longint      ramp_len         = 240;

  gained_t due_samples [$];
  int      bad_results    = 0;
  int      results_seen   = 0;
  int      items_sent     = 0;
  int      levels_sent    = 0;
  int      cfg_writes     = 0;
  int      cycles         = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor square root, bit by bit.
  function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = n;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Level in hundredths of a dB to Q4.24 gain: 2^int times a product of roots.
  function automatic logic [63:0] level_to_gain(input logic signed [CDB_W-1:0] cdb);
    longint      e10;
    longint      ipart;
    longint      sh;
    logic [63:0] u;
    logic [63:0] p;
    e10   = (longint'(cdb) * DB_EXP_Q16 + 32768) >>> 16;
    u     = 64'(e10 + 65536);
    ipart = longint'(u >> 10) - 64;
    p     = 64'd1 << 30;
    for (int k = 0; k < ROOT_COUNT; k++) begin
      if (u[ROOT_COUNT-1-k]) p = (p * pow_roots[k]) >> 30;
    end
    sh = ipart + GAIN_FRAC - 30;
    if (sh > 33) return GAIN_TOP;
    if (sh >= 0) begin
      p = p << sh;
      return (p > GAIN_TOP) ? GAIN_TOP : p;
    end
    if (sh <= -63) return '0;
    return p >> (-sh);
  endfunction

  // Advances the predicted state by one transaction; returns 1 with the
  // expected result for a sample, 0 for a level change.
  function automatic bit advance_volume_state(input vol_item_t it, output gained_t res);
    longint      frames;
    logic [63:0] g;
    longint      y;
    res = '0;
    if (it.cmd == CMD_VOLUME) begin
      frames    = (ramp_len == 0) ? 1 : ramp_len;
      goal_gain = level_to_gain(it.cdb);
      if (!level_applied) begin
        run_gain         = goal_gain << EXTRA_W;
        ramp_inc         = 0;
        ramp_frames_left = 0;
        level_applied    = 1'b1;
      end else begin
        ramp_inc = (longint'(goal_gain << EXTRA_W) - longint'(run_gain)) / frames;
        ramp_frames_left = frames;
      end
      return 1'b0;
    end

    // Frame start moves the gain one step; the last step lands on the goal.
    if (it.fs && ramp_frames_left != 0) begin
      run_gain = run_gain + ramp_inc;
      ramp_frames_left--;
      if (ramp_frames_left == 0) run_gain = goal_gain << EXTRA_W;
    end

    g = run_gain >> EXTRA_W;
    y = (longint'(it.smp) * longint'(g) + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (y > SMP_HI) y = SMP_HI;
    if (y < SMP_LO) y = SMP_LO;
    res.smp  = SAMPLE_W'(y);
    res.gain = GAIN_W'(g & GAIN_TOP);
    return 1'b1;
  endfunction

  function automatic void set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 8;
        recv_idle_pct = 61;
      end
      1: begin
        send_idle_pct = 61;
        recv_idle_pct = 8;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // Sends one transaction and records what it should produce.
  task automatic push_item(input vol_item_t it, input bit typed, input gained_t want);
    gained_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.command         <= it.cmd;
    in_if.sample_in       <= it.smp;
    in_if.frame_start     <= it.fs;
    in_if.volume_centi_db <= it.cdb;
    do @(posedge clk); while (!in_if.ready);
    if (advance_volume_state(it, got)) due_samples.push_back(typed ? want : got);
    items_sent++;
    if (it.cmd == CMD_VOLUME) levels_sent++;
  endtask

  // Ramp length write once the block has drained.
  task automatic write_ramp_len(input logic [RAMP_W-1:0] len);
    in_if.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ramp_len = longint'(len);
    cfg_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(19))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [CDB_W-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CDB_W'(int'($urandom_range(12000)) - 9600);
    if (r < 85) return CDB_W'($urandom);
    case ($urandom_range(4))
      0:       return -15'sd9600;
      1:       return 15'sd2400;
      2:       return 15'sh4000;
      3:       return 15'sh3FFF;
      default: return '0;
    endcase
  endfunction

  // Random framed traffic: frames of a few channels, level changes at frame
  // boundaries, and some frame marks scrambled.
  task automatic run_phase(input logic [RAMP_W-1:0] len, input int n_items);
    vol_item_t it;
    gained_t   none;
    int        chans;
    int        pos;
    none = '0;
    write_ramp_len(len);
    chans = $urandom_range(1, 4);
    pos   = 0;
    for (int n = 0; n < n_items; n++) begin
      it.cmd = CMD_SAMPLE;
      it.smp = pick_sample();
      it.cdb = CDB_W'($urandom);
      it.fs  = (pos == 0);
      if (pos == 0 && $urandom_range(9) == 0) begin
        it.cmd = CMD_VOLUME;
        it.cdb = pick_level();
        it.fs  = 1'($urandom);
      end else begin
        if ($urandom_range(9) == 0) it.fs = 1'($urandom);
        pos = (pos + 1) % chans;
      end
      push_item(it, 1'b0, none);
    end
  endtask

  // Result side: random back-pressure and in-order comparison.
  initial begin
    gained_t want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        results_seen++;
        if (due_samples.size() == 0) begin
          $display("%0t: unexpected result, sample_out %0d gain_used 0x%07h", $time,
                   out_if.sample_out, out_if.gain_used);
          bad_results++;
        end else begin
          want = due_samples.pop_front();
          if (out_if.sample_out !== want.smp) begin
            $display("%0t: sample_out expected %0d, actual %0d", $time, want.smp,
                     out_if.sample_out);
            bad_results++;
          end
          if (out_if.gain_used !== want.gain) begin
            $display("%0t: gain_used expected 0x%07h, actual 0x%07h", $time, want.gain,
                     out_if.gain_used);
            bad_results++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding", cycles,
               due_samples.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    logic [63:0]       r;
    logic [RAMP_W-1:0] lens [PHASES];
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.command         = CMD_SAMPLE;
    in_if.sample_in       = '0;
    in_if.frame_start     = 1'b0;
    in_if.volume_centi_db = '0;

    // Factors 2^(2^-k) in Q30 by repeated square roots of 2.0.
    r = 64'd1 << 31;
    for (int k = 0; k < ROOT_COUNT; k++) begin
      r            = sqrt_floor(r << 30);
      pow_roots[k] = r;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) write_ramp_len(PLAN[i].cfg_val);
      else push_item(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
    end

    lens = '{12'd1, 12'd0, 12'hFFF, 12'd5, RAMP_W'($urandom_range(2, 40)), 12'd240};
    for (int ph = 0; ph < PHASES; ph++) begin
      set_idling(ph / 2);
      run_phase(lens[ph], PHASE_ITEMS);
    end

    in_if.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d level changes) over %0d ramp length settings,",
             items_sent, levels_sent, cfg_writes);
    $display("checked %0d results under three idle patterns in %0d cycles", results_seen,
             cycles);
    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
